@@ rtl/core/dir_pkg.sv @@
// Package for the dense id renumbering block: field widths, codes and item types.
`default_nettype none
package dir_pkg;

   localparam int ID_W         = 10;
   localparam int CNT_W        = 11;
   localparam int OP_W         = 2;
   localparam int ID_SPACE_DEF = 1024;

   // op codes
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_MARK  = 2'd1;
   localparam logic [OP_W-1:0] OP_REMAP = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [ID_W-1:0] old_id;
      logic            entry_valid;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]  new_id;
      logic             new_valid;
      logic [CNT_W-1:0] distinct_count;
   } rsp_type;

   // one word of the id table: presence bit and assigned rank
   typedef struct packed {
      logic            present;
      logic [ID_W-1:0] rank;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_MARK,
      ST_RANK,
      ST_LOOKUP,
      ST_REMAP
   } state_type;

endpackage
`default_nettype wire

@@ rtl/core/dense_id_renumbering_top.sv @@
// Dense id renumbering: presence/rank table in one RAM, driven by a sequencer.
// Reset runs a clearing pass over the table; no item is taken meanwhile. Mark sets the
// presence bit of a valid in-range id, else is dropped. Clear sweeps ids 0..highest_seen.
// Remap with stale ranks first runs the rank pass over ids 0..highest_seen, one RAM read
// a cycle, then reads the id; the result is registered once the output register is free.
// One item in flight at a time, set by the single read/write port pair of the table RAM.
`default_nettype none
module dense_id_renumbering_top #(
   parameter int ID_SPACE = dir_pkg::ID_SPACE_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire dir_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output dir_pkg::rsp_type      rsp_data
);

   localparam int AW    = $clog2(ID_SPACE);
   localparam int ID_W  = dir_pkg::ID_W;
   localparam int CNT_W = dir_pkg::CNT_W;

   // sequencer state
   dir_pkg::state_type state_ff, state_in;

   // control registers
   logic [ID_W-1:0]  highest_ff;
   logic [CNT_W-1:0] total_ff;
   logic             ranks_ready_ff;
   logic [AW-1:0]    sweep_ff;
   logic [AW-1:0]    sweep_last_ff;
   logic             issue_ff;
   logic             pend_ff;
   logic             rsp_valid_ff;

   // payload registers
   logic [ID_W-1:0]  lat_id_ff;
   logic             lat_valid_ff;
   logic [ID_W-1:0]  walk_ff;
   logic [AW-1:0]    pend_addr_ff;
   logic [ID_W-1:0]  next_rank_ff;
   dir_pkg::rsp_type rsp_ff;

   // table RAM
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   dir_pkg::entry_type ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   dir_pkg::entry_type ram_rd_data;

   logic accept;
   logic req_in_range;
   logic lat_in_range;
   logic rank_write;
   logic rsp_load;
   logic hit;

   assign req_ready    = (state_ff == dir_pkg::ST_IDLE);
   assign accept       = req_valid && req_ready;
   assign req_in_range = 32'(req_data.old_id) < ID_SPACE;
   assign lat_in_range = 32'(lat_id_ff) < ID_SPACE;

   // rank pass writes back every present id it reads, in the cycle after its read
   assign rank_write = (state_ff == dir_pkg::ST_RANK) && pend_ff && ram_rd_data.present;
   assign rsp_load   = (state_ff == dir_pkg::ST_REMAP) && (!rsp_valid_ff || rsp_ready);
   assign hit        = lat_valid_ff && lat_in_range && ram_rd_data.present;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   dir_ram #(
      .WIDTH (dir_pkg::ENTRY_W),
      .DEPTH (ID_SPACE)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dir_pkg::ST_INIT, dir_pkg::ST_CLEAR: begin
            if (sweep_ff == sweep_last_ff) begin
               state_in = dir_pkg::ST_IDLE;
            end
         end
         dir_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.op)
                  dir_pkg::OP_CLEAR: state_in = dir_pkg::ST_CLEAR;
                  dir_pkg::OP_MARK: begin
                     if (req_data.entry_valid && req_in_range) begin
                        state_in = dir_pkg::ST_MARK;
                     end
                  end
                  dir_pkg::OP_REMAP: begin
                     state_in = ranks_ready_ff ? dir_pkg::ST_REMAP : dir_pkg::ST_RANK;
                  end
                  default: state_in = dir_pkg::ST_IDLE;  // unused op: dropped
               endcase
            end
         end
         dir_pkg::ST_MARK:   state_in = dir_pkg::ST_IDLE;
         dir_pkg::ST_RANK: begin
            if (!issue_ff && !pend_ff) begin
               state_in = dir_pkg::ST_LOOKUP;
            end
         end
         dir_pkg::ST_LOOKUP: state_in = dir_pkg::ST_REMAP;
         dir_pkg::ST_REMAP: begin
            if (rsp_load) begin
               state_in = dir_pkg::ST_IDLE;
            end
         end
         default: state_in = dir_pkg::ST_INIT;
      endcase
   end

   // RAM port control per state
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = sweep_ff;
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = AW'(lat_id_ff);
      case (state_ff)
         dir_pkg::ST_INIT, dir_pkg::ST_CLEAR: begin
            ram_wr_en = 1'b1;
         end
         dir_pkg::ST_IDLE: begin
            // read issued with the accept; data is there in the next state
            ram_rd_en   = accept;
            ram_rd_addr = AW'(req_data.old_id);
         end
         dir_pkg::ST_MARK: begin
            ram_wr_en           = 1'b1;
            ram_wr_addr         = AW'(lat_id_ff);
            ram_wr_data.present = 1'b1;
         end
         dir_pkg::ST_RANK: begin
            // read id i while writing id i-1: never the same entry
            ram_rd_en           = issue_ff;
            ram_rd_addr         = AW'(walk_ff);
            ram_wr_en           = rank_write;
            ram_wr_addr         = pend_addr_ff;
            ram_wr_data.present = 1'b1;
            ram_wr_data.rank    = next_rank_ff;
         end
         dir_pkg::ST_LOOKUP: begin
            ram_rd_en = 1'b1;
         end
         default: begin
            // remap: read data held until the result register frees up
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= dir_pkg::ST_INIT;
         highest_ff     <= '0;
         total_ff       <= '0;
         ranks_ready_ff <= 1'b0;
         sweep_ff       <= '0;
         sweep_last_ff  <= AW'(ID_SPACE - 1);
         issue_ff       <= 1'b0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            dir_pkg::ST_INIT, dir_pkg::ST_CLEAR: begin
               sweep_ff <= sweep_ff + AW'(1);
            end
            dir_pkg::ST_IDLE: begin
               if (accept && req_data.op == dir_pkg::OP_CLEAR) begin
                  // only ids up to highest_seen can hold a presence bit
                  highest_ff     <= '0;
                  total_ff       <= '0;
                  ranks_ready_ff <= 1'b0;
                  sweep_ff       <= '0;
                  sweep_last_ff  <= AW'(highest_ff);
               end
               if (accept && req_data.op == dir_pkg::OP_REMAP && !ranks_ready_ff) begin
                  issue_ff <= 1'b1;
                  pend_ff  <= 1'b0;
               end
            end
            dir_pkg::ST_MARK: begin
               if (!ram_rd_data.present) begin
                  total_ff <= total_ff + CNT_W'(1);
               end
               if (lat_id_ff > highest_ff) begin
                  highest_ff <= lat_id_ff;
               end
               ranks_ready_ff <= 1'b0;
            end
            dir_pkg::ST_RANK: begin
               pend_ff <= issue_ff;
               if (issue_ff && walk_ff == highest_ff) begin
                  issue_ff <= 1'b0;
               end
               if (!issue_ff && !pend_ff) begin
                  ranks_ready_ff <= 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         lat_id_ff    <= req_data.old_id;
         lat_valid_ff <= req_data.entry_valid;
      end
      if (accept && req_data.op == dir_pkg::OP_REMAP && !ranks_ready_ff) begin
         walk_ff      <= '0;
         next_rank_ff <= '0;
      end
      if (state_ff == dir_pkg::ST_RANK && issue_ff) begin
         pend_addr_ff <= AW'(walk_ff);
         walk_ff      <= walk_ff + ID_W'(1);
      end
      if (rank_write) begin
         next_rank_ff <= next_rank_ff + ID_W'(1);
      end
      if (rsp_load) begin
         rsp_ff.new_id         <= hit ? ram_rd_data.rank : '0;
         rsp_ff.new_valid      <= hit;
         rsp_ff.distinct_count <= total_ff;
      end
   end

   // checks
   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(total_ff) <= ID_SPACE)
      else $error("distinct count exceeds id space");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dir_pkg::ST_IDLE) |-> !ram_wr_en)
      else $error("table written while idle");

   a_pass_sets_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dir_pkg::ST_RANK && state_in == dir_pkg::ST_LOOKUP) |=> ranks_ready_ff)
      else $error("rank pass ended without ranks ready");

   a_rank_in_count: assert property (@(posedge clock) disable iff (reset)
      rank_write |-> (CNT_W'(next_rank_ff) < total_ff))
      else $error("rank assigned beyond distinct count");

endmodule
`default_nettype wire

@@ rtl/core/dir_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none
module dir_ram #(
   parameter int WIDTH = dir_pkg::ENTRY_W,
   parameter int DEPTH = dir_pkg::ID_SPACE_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ dv/tb_dense_id_renumbering_top.sv @@
// Testbench for dense_id_renumbering_top: directed and random items against a rank predictor.
module tb_dense_id_renumbering_top;
   timeunit 1ns;
   timeprecision 1ps;

   // Op value 3 has no meaning; the block must drop it without a result.
   localparam logic [dir_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int HALF_PERIOD = 6;
   localparam int ID_MAX      = dir_pkg::ID_SPACE_DEF - 1;

   // After the last result, a trailing mark or clear may still be walking the table.
   localparam int DRAIN_CYCLES = 2 * dir_pkg::ID_SPACE_DEF + 16;

   // Worst case per item: a rank pass over the whole id space plus long stalls on both
   // sides, for roughly 1900 items and the clearing pass after reset, then taken four
   // times over.
   localparam longint LIMIT_CYCLES = 8_500_000;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   dir_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   dir_pkg::rsp_type rsp_data;

   // Predictor state: presence per id, ranks from the last rank pass, and counters.
   bit                       id_present [dir_pkg::ID_SPACE_DEF];
   logic [dir_pkg::ID_W-1:0] id_rank [dir_pkg::ID_SPACE_DEF];
   bit                       ranks_current;
   int unsigned              top_id;
   int unsigned              distinct_ids;

   // Answers owed by the block, oldest first.
   dir_pkg::rsp_type expected_ranks[$];

   int unsigned items_sent    = 0;
   int unsigned error_count   = 0;
   int unsigned send_idle_pct = 16;
   int unsigned recv_idle_pct = 67;
   // A nonzero value asks the receiver to hold off while it counts that value down.
   int unsigned hold_request  = 0;

   dense_id_renumbering_top #(
      .ID_SPACE(dir_pkg::ID_SPACE_DEF)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   function automatic dir_pkg::req_type make_entry(input logic [dir_pkg::OP_W-1:0] op,
                                                   input int unsigned id,
                                                   input logic valid);
      dir_pkg::req_type item;
      item.op          = op;
      item.old_id      = dir_pkg::ID_W'(id);
      item.entry_valid = valid;
      return item;
   endfunction

   // Advance the predictor by one accepted item; a remap queues the answer it owes.
   task automatic track_entry(input dir_pkg::req_type item);
      dir_pkg::rsp_type want;
      int unsigned      next_rank;
      case (item.op)
         dir_pkg::OP_CLEAR: begin
            id_present    = '{default: 1'b0};
            ranks_current = 1'b0;
            top_id        = 0;
            distinct_ids  = 0;
         end
         dir_pkg::OP_MARK: begin
            // An invalid entry marks nothing and leaves the ranks alone.
            if (item.entry_valid) begin
               if (!id_present[item.old_id]) begin
                  id_present[item.old_id] = 1'b1;
                  distinct_ids++;
               end
               if (item.old_id > top_id) top_id = 32'(item.old_id);
               ranks_current = 1'b0;
            end
         end
         dir_pkg::OP_REMAP: begin
            // First remap after any mark or clear: number the present ids in ascending order.
            if (!ranks_current) begin
               next_rank = 0;
               for (int i = 0; i <= top_id; i++) begin
                  if (id_present[i]) begin
                     id_rank[i] = dir_pkg::ID_W'(next_rank);
                     next_rank++;
                  end
               end
               ranks_current = 1'b1;
            end
            // Invalid entries and ids never marked answer rank 0, not valid.
            want = '0;
            if (item.entry_valid && id_present[item.old_id]) begin
               want.new_id    = id_rank[item.old_id];
               want.new_valid = 1'b1;
            end
            want.distinct_count = dir_pkg::CNT_W'(distinct_ids);
            expected_ranks = {expected_ranks, want};
         end
         default: ;
      endcase
   endtask

   // Offer one item, with random idle cycles ahead of it, and wait until it is taken.
   task automatic send_entry(input dir_pkg::req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      track_entry(item);
      items_sent++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   // Result side: checks every result and drives rsp_ready, with random idling
   // and, on request, one long hold-off counted here.
   initial begin : rsp_side
      int unsigned      hold_left;
      dir_pkg::rsp_type want;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            if (expected_ranks.size() == 0) begin
               error_count++;
               $display({"%0t ns: item with nothing expected, ",
                         "actual new_id %0d new_valid %0d count %0d"},
                        $time, rsp_data.new_id, rsp_data.new_valid, rsp_data.distinct_count);
            end else begin
               want = expected_ranks.pop_front();
               compare_field("new_id", 32'(want.new_id), 32'(rsp_data.new_id));
               compare_field("new_valid", 32'(want.new_valid), 32'(rsp_data.new_valid));
               compare_field("distinct_count", 32'(want.distinct_count),
                             32'(rsp_data.distinct_count));
            end
         end
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Remap straight after reset: nothing marked, so the rank pass finds nothing.
   task automatic test_empty_remap();
      send_entry(make_entry(dir_pkg::OP_REMAP, ID_MAX, 1'b1));
   endtask

   // Unused op values and an invalid mark must leave the state untouched.
   task automatic test_ignored_items();
      send_entry(make_entry(OP_UNUSED, ID_MAX, 1'b1));
      send_entry(make_entry(OP_UNUSED, 0, 1'b0));
      send_entry(make_entry(dir_pkg::OP_MARK, 7, 1'b0));
      send_entry(make_entry(dir_pkg::OP_REMAP, 7, 1'b1));
   endtask

   // Extreme and alternating ids, a repeated mark, an unmarked id and an invalid entry.
   task automatic test_mark_and_remap();
      send_entry(make_entry(dir_pkg::OP_MARK, 0, 1'b1));
      send_entry(make_entry(dir_pkg::OP_MARK, ID_MAX, 1'b1));
      send_entry(make_entry(dir_pkg::OP_MARK, 341, 1'b1));
      send_entry(make_entry(dir_pkg::OP_MARK, 682, 1'b1));
      send_entry(make_entry(dir_pkg::OP_MARK, 512, 1'b1));
      send_entry(make_entry(dir_pkg::OP_MARK, 512, 1'b1));
      send_entry(make_entry(dir_pkg::OP_REMAP, 0, 1'b1));
      send_entry(make_entry(dir_pkg::OP_REMAP, 341, 1'b1));
      send_entry(make_entry(dir_pkg::OP_REMAP, 512, 1'b1));
      send_entry(make_entry(dir_pkg::OP_REMAP, 682, 1'b1));
      send_entry(make_entry(dir_pkg::OP_REMAP, ID_MAX, 1'b1));
      send_entry(make_entry(dir_pkg::OP_REMAP, 100, 1'b1));
      send_entry(make_entry(dir_pkg::OP_REMAP, 512, 1'b0));
   endtask

   // A mark between remaps must force a fresh rank pass that shifts the higher ranks.
   task automatic test_rank_rebuild();
      send_entry(make_entry(dir_pkg::OP_MARK, 3, 1'b1));
      send_entry(make_entry(dir_pkg::OP_REMAP, ID_MAX, 1'b1));
      send_entry(make_entry(dir_pkg::OP_REMAP, 3, 1'b1));
   endtask

   task automatic test_clear();
      send_entry(make_entry(dir_pkg::OP_CLEAR, 0, 1'b1));
      send_entry(make_entry(dir_pkg::OP_REMAP, ID_MAX, 1'b1));
      send_entry(make_entry(dir_pkg::OP_REMAP, 0, 1'b1));
   endtask

   // Receiver holds off for a long stretch while remaps keep coming, so the block
   // backs up and stalls its input.
   task automatic test_backpressure();
      send_entry(make_entry(dir_pkg::OP_CLEAR, 0, 1'b0));
      send_entry(make_entry(dir_pkg::OP_MARK, 5, 1'b1));
      send_entry(make_entry(dir_pkg::OP_MARK, 9, 1'b1));
      send_entry(make_entry(dir_pkg::OP_MARK, 40, 1'b1));
      hold_request = 400;
      repeat (10) send_entry(make_entry(dir_pkg::OP_REMAP, $urandom_range(48), 1'b1));
      send_entry(make_entry(dir_pkg::OP_MARK, 2, 1'b1));
      send_entry(make_entry(dir_pkg::OP_REMAP, 40, 1'b1));
   endtask

   // Mostly well-formed sessions (clear, marks, remaps) over a small id span, now and
   // then the full span; the rest is noise. Some sessions skip the clear and build on
   // what is already marked.
   task automatic test_random_traffic(input int unsigned goal);
      int unsigned stop_at;
      int unsigned span;
      int unsigned count;
      int unsigned pick;
      int unsigned id;
      int unsigned marked[$];
      stop_at = items_sent + goal;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 85) begin
            // Small spans keep rank passes short; the full span is rare.
            span = ($urandom_range(15) == 0) ? ID_MAX : $urandom_range(63, 1);
            if ($urandom_range(7) != 0) begin
               send_entry(make_entry(dir_pkg::OP_CLEAR, $urandom_range(ID_MAX),
                                     1'($urandom_range(1))));
               marked.delete();
            end
            count = $urandom_range(16, 1);
            repeat (count) begin
               id = $urandom_range(span);
               send_entry(make_entry(dir_pkg::OP_MARK, id, ($urandom_range(9) != 0)));
               marked = {marked, id};
            end
            count = $urandom_range(12, 1);
            repeat (count) begin
               pick = $urandom_range(99);
               if (pick < 8) begin
                  // late mark: the next remap has to renumber
                  id = $urandom_range(span);
                  send_entry(make_entry(dir_pkg::OP_MARK, id, 1'b1));
                  marked = {marked, id};
               end else begin
                  if (pick < 70 && marked.size() != 0)
                     id = marked[$urandom_range(marked.size() - 1)];
                  else
                     id = $urandom_range(span);
                  send_entry(make_entry(dir_pkg::OP_REMAP, id, (pick < 88)));
               end
            end
         end else begin
            count = $urandom_range(6, 1);
            repeat (count)
               send_entry(make_entry(dir_pkg::OP_W'($urandom_range(2 ** dir_pkg::OP_W - 1)),
                                     $urandom_range(ID_MAX), 1'($urandom_range(1))));
         end
      end
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part; the block is still running its clearing pass at first, which
      // send_entry simply waits out.
      test_empty_remap();
      test_ignored_items();
      test_mark_and_remap();
      test_rank_rebuild();
      test_clear();
      test_backpressure();

      // Random part in three idling modes.
      test_random_traffic(600);
      send_idle_pct = 67;
      recv_idle_pct = 16;
      test_random_traffic(600);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(600);

      req_valid <= 1'b0;
      while (expected_ranks.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_ranks.size() == 0) begin
         $display("dense_id_renumbering_top verification clean");
      end else begin
         $display("dense_id_renumbering_top verification failed");
      end
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 2 * HALF_PERIOD);
      $display("%0t ns: timeout, %0d answers still owed", $time, expected_ranks.size());
      $display("dense_id_renumbering_top verification failed");
      $finish;
   end

endmodule

@@ dense_id_renumbering_top.f @@
rtl/core/dir_pkg.sv
rtl/core/dir_ram.sv
rtl/core/dense_id_renumbering_top.sv
dv/tb_dense_id_renumbering_top.sv
